### design/cfc_pkg.sv
// ---------------------------------------------------------------------------
// Complex FIR convolver package
// Shared widths, command codes and the control struct of the tap cells.
// ---------------------------------------------------------------------------
package cfc_pkg;

  // Kernel depth and field widths.
  localparam int MAX_TAPS  = 64;
  localparam int TAP_IDX_W = 6;
  localparam int TAP_CNT_W = 7;
  localparam int WAVE_W    = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int OUT_W     = 38;

  // Request commands; code 3 has no meaning and is dropped.
  typedef enum logic [1:0] {
    CMD_LOAD_TAP = 2'd0,
    CMD_PUSH     = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctrl_t;

endpackage

### design/cfc_if.sv
// ---------------------------------------------------------------------------
// Complex FIR convolver channels
// Valid/ready channels for requests, results and the tap count register.
// ---------------------------------------------------------------------------

// Request channel: tap loads, sample pushes and history clears.
interface cfc_in_if import cfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] tap_value;

  modport source (output valid, command, sample_re, sample_im, tap_index, tap_value,
                  input ready);
  modport sink   (input valid, command, sample_re, sample_im, tap_index, tap_value,
                  output ready);
endinterface

// Result channel: one complex output per pushed sample.
interface cfc_out_if import cfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_re;
  logic signed [OUT_W-1:0] out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink   (input valid, out_re, out_im, output ready);
endinterface

// Configuration channel: writes the tap count register.
interface cfc_cfg_if import cfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TAP_CNT_W-1:0] tap_count;

  modport source (output valid, tap_count, input ready);
  modport sink   (input valid, tap_count, output ready);
endinterface

### design/cfc_cell.sv
// ---------------------------------------------------------------------------
// Complex FIR tap cell
// Holds one tap and one history sample; when active, adds its product to the
// partial sum that moves down the chain one cell per cycle.
// ---------------------------------------------------------------------------
module cfc_cell import cfc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctrl_t                 ctrl,
  input  logic                       active,
  input  logic signed [SAMPLE_W-1:0] tap_value,
  input  logic signed [SAMPLE_W-1:0] x_re_i,
  input  logic signed [SAMPLE_W-1:0] x_im_i,
  output logic signed [SAMPLE_W-1:0] x_re_o,
  output logic signed [SAMPLE_W-1:0] x_im_o,
  input  logic signed [OUT_W-1:0]    sum_re_i,
  input  logic signed [OUT_W-1:0]    sum_im_i,
  output logic signed [OUT_W-1:0]    sum_re_o,
  output logic signed [OUT_W-1:0]    sum_im_o
);

  logic signed [SAMPLE_W-1:0] tap_r;
  logic signed [SAMPLE_W-1:0] hist_re_r;
  logic signed [SAMPLE_W-1:0] hist_im_r;
  logic signed [PROD_W-1:0]   prod_re;
  logic signed [PROD_W-1:0]   prod_im;
  logic signed [OUT_W-1:0]    sum_re_r;
  logic signed [OUT_W-1:0]    sum_im_r;
  logic signed [OUT_W-1:0]    sum_re_nxt;
  logic signed [OUT_W-1:0]    sum_im_nxt;

  // History sample: shifts in from the neighbor on a push, zeroed on a clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_re_r <= '0;
      hist_im_r <= '0;
    end else if (ctrl.clear) begin
      hist_re_r <= '0;
      hist_im_r <= '0;
    end else if (ctrl.shift) begin
      hist_re_r <= x_re_i;
      hist_im_r <= x_im_i;
    end
  end

  // Coefficient is undefined until loaded, so it carries no reset.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tap_r <= tap_value;
    end
  end

  // Product and partial sum; a cell beyond the tap count passes the sum on.
  always_comb begin
    prod_re = tap_r * hist_re_r;
    prod_im = tap_r * hist_im_r;
    if (active) begin
      sum_re_nxt = sum_re_i + OUT_W'(prod_re);
      sum_im_nxt = sum_im_i + OUT_W'(prod_im);
    end else begin
      sum_re_nxt = sum_re_i;
      sum_im_nxt = sum_im_i;
    end
  end

  always_ff @(posedge clk) begin
    sum_re_r <= sum_re_nxt;
    sum_im_r <= sum_im_nxt;
  end

  assign x_re_o   = hist_re_r;
  assign x_im_o   = hist_im_r;
  assign sum_re_o = sum_re_r;
  assign sum_im_o = sum_im_r;

endmodule

### design/complex_fir_convolver_top.sv
// A push request yields its result once its partial sum has walked the
// 64-cell tap chain into the output register. Tap loads and history clears
// give no result. No request is accepted while a push is in flight; the
// chain frees once its result is registered, and a push also waits for output room.
// Reset: tap count is 1 and the history is zero; taps are undefined until loaded.
// ---------------------------------------------------------------------------
// Complex FIR convolver top level
// Direct-form convolution of a complex sample stream with a real kernel,
// built as a chain of tap cells with a full-precision output register.
// ---------------------------------------------------------------------------
module complex_fir_convolver_top import cfc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cfc_in_if.sink    in_ch,
  cfc_out_if.source out_ch,
  cfc_cfg_if.sink   cfg_ch
);

  logic                       in_fire;
  logic                       out_fire;
  logic                       is_push;
  logic [TAP_CNT_W-1:0]       tap_count_r;
  logic [TAP_CNT_W-1:0]       taps_used;
  logic                       busy_r;
  logic [WAVE_W-1:0]          wave_cnt_r;
  logic                       wave_done;
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_re_r;
  logic signed [OUT_W-1:0]    out_im_r;
  cell_ctrl_t                 ctrl   [MAX_TAPS];
  logic                       active [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] x_re_c [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] x_im_c [MAX_TAPS];
  logic signed [OUT_W-1:0]    sum_re_c [MAX_TAPS];
  logic signed [OUT_W-1:0]    sum_im_c [MAX_TAPS];

  // Handshakes. A push waits until the output register will be free.
  assign is_push      = (in_ch.command == CMD_PUSH);
  assign in_ch.ready  = !busy_r && (!is_push || !out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Tap count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_CNT_W'(1);
    end else if (cfg_ch.valid) begin
      tap_count_r <= cfg_ch.tap_count;
    end
  end

  // Clamp the tap count to the range of the chain.
  always_comb begin
    if (tap_count_r == '0) begin
      taps_used = TAP_CNT_W'(1);
    end else if (tap_count_r > TAP_CNT_W'(MAX_TAPS)) begin
      taps_used = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_used = tap_count_r;
    end
  end

  // Sum wave tracking: the wave counter reaches MAX_TAPS when the last cell holds the full sum.
  assign wave_done = busy_r && (wave_cnt_r == WAVE_W'(MAX_TAPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      wave_cnt_r <= '0;
    end else if (in_fire && is_push) begin
      busy_r     <= 1'b1;
      wave_cnt_r <= '0;
    end else if (wave_done) begin
      busy_r     <= 1'b0;
    end else if (busy_r) begin
      wave_cnt_r <= wave_cnt_r + WAVE_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wave_done) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wave_done) begin
      out_re_r <= sum_re_c[MAX_TAPS-1];
      out_im_r <= sum_im_c[MAX_TAPS-1];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_re = out_re_r;
  assign out_ch.out_im = out_im_r;

  // Tap cell chain.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    always_comb begin
      ctrl[k].shift = in_fire && is_push;
      ctrl[k].clear = in_fire && (in_ch.command == CMD_CLEAR);
      ctrl[k].load  = in_fire && (in_ch.command == CMD_LOAD_TAP) &&
                      (in_ch.tap_index == TAP_IDX_W'(k));
      active[k]     = (TAP_CNT_W'(k) < taps_used);
    end

    if (k == 0) begin : g_head
      cfc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl[k]),
        .active    (active[k]),
        .tap_value (in_ch.tap_value),
        .x_re_i    (in_ch.sample_re),
        .x_im_i    (in_ch.sample_im),
        .x_re_o    (x_re_c[k]),
        .x_im_o    (x_im_c[k]),
        .sum_re_i  ('0),
        .sum_im_i  ('0),
        .sum_re_o  (sum_re_c[k]),
        .sum_im_o  (sum_im_c[k])
      );
    end else begin : g_body
      cfc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl[k]),
        .active    (active[k]),
        .tap_value (in_ch.tap_value),
        .x_re_i    (x_re_c[k-1]),
        .x_im_i    (x_im_c[k-1]),
        .x_re_o    (x_re_c[k]),
        .x_im_o    (x_im_c[k]),
        .sum_re_i  (sum_re_c[k-1]),
        .sum_im_i  (sum_im_c[k-1]),
        .sum_re_o  (sum_re_c[k]),
        .sum_im_o  (sum_im_c[k])
      );
    end
  end

endmodule
